@@ design/hfke_pkg.sv @@
// shared constants, event codes and the queued job record for the frame-to-event block
package hfke_pkg;

  localparam logic [7:0] FRAME_MAGIC   = 8'h57;
  localparam logic [7:0] KIND_KEYBOARD = 8'h02;
  localparam logic [7:0] KIND_MOUSE    = 8'h05;
  localparam logic [7:0] MODIFIER_BASE = 8'h80;

  localparam int INPUT_SLOTS = 6;
  localparam int SLOT_IDX_W  = $clog2(INPUT_SLOTS);
  localparam int MOD_BITS    = 8;
  localparam int MOD_IDX_W   = $clog2(MOD_BITS);
  localparam int BTN_MAX     = 8;
  localparam int BTN_IDX_W   = $clog2(BTN_MAX);

  // pending-event vector layout, keyboard: releases, modifiers, presses
  localparam int REL_IDX   = 0;
  localparam int MOD_IDX   = REL_IDX + INPUT_SLOTS;
  localparam int PRESS_IDX = MOD_IDX + MOD_BITS;
  localparam int EV_MAX    = PRESS_IDX + INPUT_SLOTS;
  // mouse: move first, then buttons
  localparam int MOVE_IDX  = 0;
  localparam int BTN_IDX   = 1;
  localparam int EV_IDX_W  = $clog2(EV_MAX);

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    EV_KEY_PRESS   = 3'd0,
    EV_KEY_RELEASE = 3'd1,
    EV_MOUSE_MOVE  = 3'd2,
    EV_BTN_PRESS   = 3'd3,
    EV_BTN_RELEASE = 3'd4
  } ev_kind_t;

  typedef struct packed {
    logic                                is_mouse;
    logic [EV_MAX-1:0]                   pend;
    logic [INPUT_SLOTS-1:0][7:0]         old_keys;
    logic [INPUT_SLOTS-1:0][7:0]         new_keys;
    logic [MOD_BITS-1:0]                 mods;
    logic [BTN_MAX-1:0]                  btns;
  } job_t;

endpackage

@@ design/hid_frame_to_key_events_top.sv @@
// top level of the frame-to-key-event converter
// Takes one keyboard or mouse frame per transaction and emits its key, modifier,
// move and button events serially, one event per clock while the output is not
// stalled; a frame causes up to twenty events, each passing through the single
// event output register. The front end diffs a frame against the held report in
// the cycle it is accepted and queues the work in a two-entry queue, so frames
// keep being accepted one per clock until the queue is full; frames that cause
// nothing are accepted but never enter the queue. The last event of each frame
// carries last_event, and the back end loads the next queued job in the same
// cycle as it registers that last event.
module hid_frame_to_key_events_top #(
  parameter int KEY_SLOTS    = 6,
  parameter int BUTTON_COUNT = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              frame_nonempty,
  input  logic [7:0]        frame_magic,
  input  logic [7:0]        frame_kind,
  input  logic [7:0]        modifier_bits,
  input  logic [7:0]        button_bits,
  input  logic [7:0]        slot_a,
  input  logic [7:0]        slot_b,
  input  logic [7:0]        slot_c,
  input  logic [7:0]        slot_d,
  input  logic [7:0]        slot_e,
  input  logic [7:0]        slot_f,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        event_kind,
  output logic [7:0]        event_code,
  output logic signed [7:0] move_x,
  output logic signed [7:0] move_y,
  output logic signed [7:0] move_wheel,
  output logic              last_event
);
  import hfke_pkg::*;

  job_t push_job;
  job_t head_job;
  logic push;
  logic full;
  logic pop;
  logic head_valid;

  assign in_ready = !full;

  hfke_front #(
    .KEY_SLOTS    (KEY_SLOTS),
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .frame_nonempty (frame_nonempty),
    .frame_magic    (frame_magic),
    .frame_kind     (frame_kind),
    .modifier_bits  (modifier_bits),
    .button_bits    (button_bits),
    .slot_a         (slot_a),
    .slot_b         (slot_b),
    .slot_c         (slot_c),
    .slot_d         (slot_d),
    .slot_e         (slot_e),
    .slot_f         (slot_f),
    .push           (push),
    .job            (push_job)
  );

  hfke_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  hfke_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_kind (event_kind),
    .event_code (event_code),
    .move_x     (move_x),
    .move_y     (move_y),
    .move_wheel (move_wheel),
    .last_event (last_event)
  );

endmodule

@@ design/hfke_front.sv @@
// front end: frame check, report diff against held state, job build
module hfke_front #(
  parameter int KEY_SLOTS    = 6,
  parameter int BUTTON_COUNT = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              frame_nonempty,
  input  logic [7:0]        frame_magic,
  input  logic [7:0]        frame_kind,
  input  logic [7:0]        modifier_bits,
  input  logic [7:0]        button_bits,
  input  logic [7:0]        slot_a,
  input  logic [7:0]        slot_b,
  input  logic [7:0]        slot_c,
  input  logic [7:0]        slot_d,
  input  logic [7:0]        slot_e,
  input  logic [7:0]        slot_f,
  output logic              push,
  output hfke_pkg::job_t    job
);
  import hfke_pkg::*;

  localparam int USED_SLOTS = (KEY_SLOTS < INPUT_SLOTS) ? KEY_SLOTS : INPUT_SLOTS;

  logic [USED_SLOTS-1:0][7:0]   prev_keys;
  logic [MOD_BITS-1:0]          prev_mods;
  logic [BUTTON_COUNT-1:0]      prev_btns;

  logic [INPUT_SLOTS-1:0][7:0]  now_keys;
  logic [BUTTON_COUNT-1:0]      btn_now;
  logic                         frame_ok;
  logic                         is_kbd;
  logic                         is_mouse;
  logic                         fire;
  logic [USED_SLOTS-1:0]        rel;
  logic [USED_SLOTS-1:0]        press;

  assign now_keys = {slot_f, slot_e, slot_d, slot_c, slot_b, slot_a};
  assign btn_now  = button_bits[BUTTON_COUNT-1:0];
  assign frame_ok = frame_nonempty && (frame_magic == FRAME_MAGIC);
  assign is_kbd   = frame_ok && (frame_kind == KIND_KEYBOARD);
  assign is_mouse = frame_ok && (frame_kind == KIND_MOUSE);
  assign fire     = in_valid && in_ready;

  // per-slot membership tests of old against new report and back
  always_comb begin
    for (int i = 0; i < USED_SLOTS; i++) begin
      logic hit_new;
      logic hit_old;
      hit_new = 1'b0;
      hit_old = 1'b0;
      for (int j = 0; j < USED_SLOTS; j++) begin
        if (now_keys[j] == prev_keys[i]) hit_new = 1'b1;
        if (prev_keys[j] == now_keys[i]) hit_old = 1'b1;
      end
      rel[i]   = (prev_keys[i] != 8'd0) && !hit_new;
      press[i] = (now_keys[i] != 8'd0) && !hit_old;
    end
  end

  always_comb begin
    job          = '0;
    job.is_mouse = is_mouse;
    job.new_keys = now_keys;
    job.mods     = modifier_bits;
    job.btns[BUTTON_COUNT-1:0] = btn_now;
    for (int i = 0; i < USED_SLOTS; i++) begin
      job.old_keys[i] = prev_keys[i];
    end
    if (is_kbd) begin
      for (int i = 0; i < USED_SLOTS; i++) begin
        job.pend[REL_IDX + i]   = rel[i];
        job.pend[PRESS_IDX + i] = press[i];
      end
      job.pend[MOD_IDX +: MOD_BITS] = modifier_bits ^ prev_mods;
    end else if (is_mouse) begin
      job.pend[MOVE_IDX] = 1'b1;
      job.pend[BTN_IDX +: BUTTON_COUNT] = btn_now ^ prev_btns;
    end
  end

  // frames with nothing to report are not queued; a valid keyboard frame still updates held state
  assign push = fire && (job.pend != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_keys <= '0;
      prev_mods <= '0;
      prev_btns <= '0;
    end else if (fire) begin
      if (is_kbd) begin
        for (int i = 0; i < USED_SLOTS; i++) begin
          prev_keys[i] <= now_keys[i];
        end
        prev_mods <= modifier_bits;
      end
      if (is_mouse) begin
        prev_btns <= btn_now;
      end
    end
  end

endmodule

@@ design/hfke_queue.sv @@
// short job queue between front and back ends
module hfke_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  hfke_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output hfke_pkg::job_t  head_job
);
  import hfke_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("queue write while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue read while empty");

endmodule

@@ design/hfke_back.sv @@
// back end: job events go in order, one per clock unless stalled, into the output register
module hfke_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  hfke_pkg::job_t  head_job,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [2:0]      event_kind,
  output logic [7:0]      event_code,
  output logic signed [7:0] move_x,
  output logic signed [7:0] move_y,
  output logic signed [7:0] move_wheel,
  output logic            last_event
);
  import hfke_pkg::*;

  job_t                 cur;
  logic                 cur_valid;
  logic [EV_IDX_W-1:0]  idx;
  logic [EV_MAX-1:0]    rest;
  logic                 emit;
  logic                 done;
  ev_kind_t             d_kind;
  logic [7:0]           d_code;
  logic [7:0]           d_x;
  logic [7:0]           d_y;
  logic [7:0]           d_w;
  logic [BTN_IDX_W-1:0] bsel;
  logic [MOD_IDX_W-1:0] msel;

  // lowest pending event goes first
  always_comb begin
    idx = '0;
    for (int i = EV_MAX - 1; i >= 0; i--) begin
      if (cur.pend[i]) idx = EV_IDX_W'(i);
    end
  end

  assign rest = cur.pend & (cur.pend - 1'b1);
  assign emit = cur_valid && (!out_valid || out_ready);
  assign done = emit && (rest == '0);
  assign pop  = head_valid && (!cur_valid || done);
  assign bsel = BTN_IDX_W'(idx - EV_IDX_W'(BTN_IDX));
  assign msel = MOD_IDX_W'(idx - EV_IDX_W'(MOD_IDX));

  always_comb begin
    d_kind = EV_KEY_PRESS;
    d_code = 8'd0;
    d_x    = 8'd0;
    d_y    = 8'd0;
    d_w    = 8'd0;
    if (cur.is_mouse) begin
      if (idx == EV_IDX_W'(MOVE_IDX)) begin
        d_kind = EV_MOUSE_MOVE;
        d_x    = cur.new_keys[0];
        d_y    = cur.new_keys[1];
        d_w    = cur.new_keys[2];
      end else begin
        d_kind = cur.btns[bsel] ? EV_BTN_PRESS : EV_BTN_RELEASE;
        d_code = 8'd1 << bsel;
      end
    end else if (idx < EV_IDX_W'(MOD_IDX)) begin
      d_kind = EV_KEY_RELEASE;
      d_code = cur.old_keys[SLOT_IDX_W'(idx - EV_IDX_W'(REL_IDX))];
    end else if (idx < EV_IDX_W'(PRESS_IDX)) begin
      d_kind = cur.mods[msel] ? EV_KEY_PRESS : EV_KEY_RELEASE;
      d_code = MODIFIER_BASE | 8'(msel);
    end else begin
      d_kind = EV_KEY_PRESS;
      d_code = cur.new_keys[SLOT_IDX_W'(idx - EV_IDX_W'(PRESS_IDX))];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // next job loads in the same cycle the last event of this one leaves
      if (pop) begin
        cur       <= head_job;
        cur_valid <= 1'b1;
      end else if (done) begin
        cur_valid <= 1'b0;
      end else if (emit) begin
        cur.pend <= rest;
      end
      if (emit) begin
        out_valid  <= 1'b1;
        event_kind <= d_kind;
        event_code <= d_code;
        move_x     <= d_x;
        move_y     <= d_y;
        move_wheel <= d_w;
        last_event <= done;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_job_nonempty: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.pend != '0))
    else $error("held job has no pending events");

  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_event) |-> cur_valid)
    else $error("non-final event shown with no job in progress");

endmodule
